[rtl/rsc_pkg.sv]
// Shared types, constants and controller/datapath interface structs for the
// RPN stack calculator. No dependencies.
package rsc_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef logic [DATA_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  localparam count_t DEPTH_CNT = count_t'(STACK_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_ADD   = 3'd1,
    FUNC_SUB   = 3'd2,
    FUNC_MUL   = 3'd3,
    FUNC_DIV   = 3'd4,
    FUNC_DRAIN = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_UNDER = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_HALT  = 3'd4
  } status_e;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    sum_clr;
    logic    sum_rd;
    logic    sum_acc;
    logic    sum_wb;
    logic    exec_sub;
    logic    exec_mul;
    logic    div_start;
    logic    div_cap;
    logic    res_wb;
    logic    emit;
    logic    drain_emit;
    logic    drain_ld;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_full;
    logic count_lt2;
    logic top_zero;
    logic idx_end;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/rpn_stack_calculator.sv]
// RPN stack calculator over 32-bit signed words, one operation per request.
// A request is taken only while the controller is idle; the result sits in an
// output register, so the next request is taken while it waits. Add-all reads
// and accumulates one RAM entry at a time, drain reads one RAM entry per new
// top, and divide uses a bit-serial divider; each result waits for a free
// output register.
// Depends on rsc_pkg, rsc_ctrl and rsc_datapath.
module rpn_stack_calculator import rsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] operand_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [COUNT_W-1:0]       count_o,
  output logic                     last_o
);

  cmd_t  cmd;
  stat_t stat;

  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

[rtl/rsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsc_div.sv]
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// Depends on rsc_pkg.
module rsc_div import rsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  done_o,
  output word_t quo_o
);

  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  logic              busy_q, fin_q;
  logic [STEP_W-1:0] step_q;
  word_t             rem_q;
  word_t             quo_q, dmag_q;
  logic              neg_q;

  logic [DATA_W:0] rem_sh, diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DATA_W-1]};
    diff   = rem_sh - {1'b0, dmag_q};
    ge     = !diff[DATA_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= num_i[DATA_W-1] ? (word_t'(0) - num_i) : num_i;
      dmag_q <= den_i[DATA_W-1] ? (word_t'(0) - den_i) : den_i;
      neg_q  <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o = fin_q;
  assign quo_o  = neg_q ? (word_t'(0) - quo_q) : quo_q;

endmodule

[rtl/rsc_datapath.sv]
// Datapath: stack RAM, cached top, entry count, accumulator, divider and the
// output register. Depends on rsc_pkg, rsc_ram and rsc_div.
module rsc_datapath import rsc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o,
  input  logic signed [DATA_W-1:0]   operand_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DATA_W-1:0]   value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [COUNT_W-1:0]         count_o,
  output logic                       last_o
);

  word_t   operand_q, top_q, acc_q, res_q;
  count_t  cnt_q, idx_q;
  logic    out_valid_q, out_last_q;
  word_t   out_value_q;
  status_e out_status_q;
  count_t  out_count_q;

  count_t second_cnt;
  addr_t  second_addr, rd_addr, wr_addr;
  logic   wr_en, out_free, div_done;
  word_t  wr_data, rd_data, quo;

  assign second_cnt  = cnt_q - count_t'(2);
  assign second_addr = second_cnt[ADDR_W-1:0];
  assign rd_addr     = cmd_i.sum_rd ? idx_q[ADDR_W-1:0] : second_addr;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = second_addr;
    wr_data = res_q;
    priority if (cmd_i.push) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[ADDR_W-1:0];
      wr_data = operand_q;
    end else if (cmd_i.sum_wb) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = acc_q;
    end else if (cmd_i.res_wb) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  rsc_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (rd_data),
    .den_i   (top_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        cnt_q <= cnt_q + count_t'(1);
      end else if (cmd_i.sum_wb) begin
        cnt_q <= count_t'(1);
      end else if (cmd_i.res_wb || cmd_i.drain_emit) begin
        cnt_q <= cnt_q - count_t'(1);
      end
      if (cmd_i.emit || cmd_i.drain_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      operand_q <= operand_i;
    end
    if (cmd_i.push) begin
      top_q <= operand_q;
    end else if (cmd_i.sum_wb) begin
      top_q <= acc_q;
    end else if (cmd_i.res_wb) begin
      top_q <= res_q;
    end else if (cmd_i.drain_ld) begin
      top_q <= rd_data;
    end
    if (cmd_i.sum_clr) begin
      acc_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.sum_rd) begin
        idx_q <= idx_q + count_t'(1);
      end
      if (cmd_i.sum_acc) begin
        acc_q <= acc_q + rd_data;
      end
    end
    if (cmd_i.exec_sub) begin
      res_q <= rd_data - top_q;
    end else if (cmd_i.exec_mul) begin
      res_q <= rd_data * top_q;
    end else if (cmd_i.div_cap) begin
      res_q <= quo;
    end
    if (cmd_i.emit) begin
      out_value_q  <= (cnt_q == '0) ? '0 : top_q;
      out_status_q <= cmd_i.status;
      out_count_q  <= cnt_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.drain_emit) begin
      out_value_q  <= top_q;
      out_status_q <= ST_OK;
      out_count_q  <= cnt_q - count_t'(1);
      out_last_q   <= (cnt_q == count_t'(1));
    end
  end

  always_comb begin
    stat_o.count_zero = (cnt_q == '0);
    stat_o.count_one  = (cnt_q == count_t'(1));
    stat_o.count_full = (cnt_q >= DEPTH_CNT);
    stat_o.count_lt2  = (cnt_q < count_t'(2));
    stat_o.top_zero   = (top_q == '0);
    stat_o.idx_end    = (idx_q == cnt_q);
    stat_o.div_done   = div_done;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("entry count above stack depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> cnt_q < DEPTH_CNT)
    else $error("push into full stack");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.drain_emit) |-> out_free)
    else $error("result overwrites pending output");

  a_sum_leaves_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum_wb |=> cnt_q == count_t'(1))
    else $error("add-all did not leave one entry");
`endif

endmodule

[rtl/rsc_ctrl.sv]
// Controller FSM: decodes each request, sequences the datapath and tracks the
// sticky halted state. Depends on rsc_pkg.
module rsc_ctrl import rsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  stat_t             stat_i,
  output cmd_t              cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SUM_RD,
    S_SUM_ACC,
    S_EXEC,
    S_DIV_WAIT,
    S_WB,
    S_RESP,
    S_DRAIN_OUT,
    S_DRAIN_LD
  } state_e;

  state_e  state_q, state_d;
  func_e   func_q, func_d;
  status_e status_q, status_d;
  logic    halted_q, halted_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = status_q;
    state_d      = state_q;
    func_d       = func_q;
    status_d     = status_q;
    halted_d     = halted_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          func_d        = func_e'(func_i);
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d  = S_RESP;
        status_d = ST_OK;
        if (halted_q) begin
          status_d = ST_HALT;
        end else begin
          unique case (func_q)
            FUNC_PUSH: begin
              if (stat_i.count_full) status_d = ST_FULL;
              else cmd_o.push = 1'b1;
            end
            FUNC_ADD: begin
              cmd_o.sum_clr = 1'b1;
              state_d       = S_SUM_RD;
            end
            FUNC_SUB, FUNC_MUL: begin
              if (stat_i.count_lt2) status_d = ST_UNDER;
              else state_d = S_EXEC;
            end
            FUNC_DIV: begin
              priority if (stat_i.count_zero) begin
                status_d = ST_UNDER;
              end else if (stat_i.top_zero) begin
                status_d = ST_DIVZ;
                halted_d = 1'b1;
              end else if (stat_i.count_lt2) begin
                status_d = ST_UNDER;
              end else begin
                state_d = S_EXEC;
              end
            end
            FUNC_DRAIN: begin
              if (!stat_i.count_zero) state_d = S_DRAIN_OUT;
            end
            default: ;
          endcase
        end
      end
      S_SUM_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.sum_wb = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.sum_rd = 1'b1;
          state_d      = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        state_d       = S_SUM_RD;
      end
      S_EXEC: begin
        if (func_q == FUNC_DIV) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_WAIT;
        end else begin
          cmd_o.exec_sub = (func_q == FUNC_SUB);
          cmd_o.exec_mul = (func_q == FUNC_MUL);
          state_d        = S_WB;
        end
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = S_WB;
        end
      end
      S_WB: begin
        cmd_o.res_wb = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DRAIN_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.drain_emit = 1'b1;
          state_d          = stat_i.count_one ? S_IDLE : S_DRAIN_LD;
        end
      end
      S_DRAIN_LD: begin
        cmd_o.drain_ld = 1'b1;
        state_d        = S_DRAIN_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      func_q   <= FUNC_PUSH;
      status_q <= ST_OK;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      func_q   <= func_d;
      status_q <= status_d;
      halted_q <= halted_d;
    end
  end

endmodule

[sim/rsc_checker.sv]
// Checker for rpn_stack_calculator: follows every accepted request, predicts
// the results on its own stack copy and compares each delivered result.
// Depends on rsc_pkg.
module rsc_checker import rsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] operand_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [STATUS_W-1:0]      status_i,
  input  logic [COUNT_W-1:0]       count_i,
  input  logic                     last_i,
  output int unsigned              errors_o,
  output int unsigned              owed_o,
  output int unsigned              checked_o,
  output int unsigned              flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t   value;
    status_e status;
    count_t  count;
    logic    last;
  } calc_res_t;

  calc_res_t   owed_q[$];
  word_t       mem [STACK_DEPTH];
  int unsigned depth;
  logic        halted;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors_o++;
    if (errors_o <= 20) begin
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    end
  endtask

  function automatic word_t top_word();
    return (depth == 0) ? '0 : mem[depth-1];
  endfunction

  function automatic void post(input word_t v, input status_e st, input logic lst);
    calc_res_t r;
    r.value  = v;
    r.status = st;
    r.count  = count_t'(depth);
    r.last   = lst;
    owed_q.push_back(r);
    if (st != ST_OK) flagged_o++;
  endfunction

  function automatic void stack_apply(input logic [FUNC_W-1:0] fn, input word_t opnd);
    word_t   lhs, rhs, sum, nmag, dmag, quo;
    status_e st;
    int      i;
    st = ST_OK;
    if (halted) begin
      post(top_word(), ST_HALT, 1'b1);
      return;
    end
    case (fn)
      FUNC_PUSH: begin
        if (depth == STACK_DEPTH) st = ST_FULL;
        else begin
          mem[depth] = opnd;
          depth++;
        end
      end
      FUNC_ADD: begin
        sum = '0;
        for (i = 0; i < depth; i++) sum += mem[i];
        mem[0] = sum;
        depth  = 1;
      end
      FUNC_SUB, FUNC_MUL: begin
        if (depth < 2) st = ST_UNDER;
        else begin
          rhs = mem[depth-1];
          lhs = mem[depth-2];
          mem[depth-2] = (fn == FUNC_SUB) ? lhs - rhs : lhs * rhs;
          depth--;
        end
      end
      FUNC_DIV: begin
        if (depth == 0) st = ST_UNDER;
        else if (mem[depth-1] == '0) begin
          st     = ST_DIVZ;
          halted = 1'b1;
        end else if (depth < 2) st = ST_UNDER;
        else begin
          rhs  = mem[depth-1];
          lhs  = mem[depth-2];
          nmag = lhs[DATA_W-1] ? -lhs : lhs;
          dmag = rhs[DATA_W-1] ? -rhs : rhs;
          quo  = nmag / dmag;
          mem[depth-2] = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
          depth--;
        end
      end
      FUNC_DRAIN: begin
        if (depth != 0) begin
          while (depth != 0) begin
            depth--;
            post(mem[depth], ST_OK, depth == 0);
          end
          return;
        end
      end
      default: ;
    endcase
    post(top_word(), st, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    calc_res_t want;
    if (!rst_ni) begin
      owed_q.delete();
      depth     = 0;
      halted    = 1'b0;
      errors_o  = 0;
      checked_o = 0;
      flagged_o = 0;
    end else begin
      // result first: it belongs to a request taken at an earlier edge
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (owed_q.size() == 0) begin
          report_mismatch("unrequested result", value_i, '0);
        end else begin
          want = owed_q.pop_front();
          if (value_i !== want.value) report_mismatch("value", value_i, want.value);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (count_i !== want.count) report_mismatch("count", count_i, want.count);
          if (last_i !== want.last) report_mismatch("last", last_i, want.last);
        end
      end
      if (in_valid_i && in_ready_i) stack_apply(func_i, operand_i);
    end
    owed_o = owed_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the rpn_stack_calculator bench: clock, reset, request and result
// drivers, watchdog and verdict. Depends on rsc_pkg and rsc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP6   = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_NOP7   = 3'd7;
  localparam int unsigned       RAND_REQS   = 480;
  localparam int unsigned       STALL_LIMIT = 2000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [FUNC_W-1:0]        func_i      = FUNC_PUSH;
  logic signed [DATA_W-1:0] operand_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] value_o;
  logic [STATUS_W-1:0]      status_o;
  logic [COUNT_W-1:0]       count_o;
  logic                     last_o;

  int unsigned errors, owed, checked, flagged;
  int unsigned n_sent = 0;
  int unsigned n_directed = 0;
  logic        calm_tx = 1'b0;

  rpn_stack_calculator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .last_o     (last_o)
  );

  rsc_checker i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .func_i     (func_i),
    .operand_i  (operand_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_i    (value_o),
    .status_i   (status_o),
    .count_i    (count_o),
    .last_i     (last_o),
    .errors_o   (errors),
    .owed_o     (owed),
    .checked_o  (checked),
    .flagged_o  (flagged)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      4:       return word_t'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic word_t rand_nonzero();
    word_t v;
    v = rand_word();
    return (v == '0) ? 32'd1 : v;
  endfunction

  task automatic send_req(input logic [FUNC_W-1:0] fn, input word_t opnd);
    int unsigned gap;
    if (n_sent % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    gap = calm_tx ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i     <= fn;
    operand_i  <= opnd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
    n_sent++;
  endtask

  // operand is ignored here, so it carries random bits
  task automatic do_op(input logic [FUNC_W-1:0] fn);
    send_req(fn, $urandom());
  endtask

  // result side: random back-pressure, calm stretches, one long hold-off
  initial begin : sink
    int unsigned gap, taken;
    logic        calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 3);
      if (taken == 150) gap = 300;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stim
    int unsigned kind, reps, i;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty-stack corners
    do_op(FUNC_DRAIN);
    do_op(FUNC_SUB);
    do_op(FUNC_MUL);
    do_op(FUNC_DIV);
    do_op(FUNC_ADD);
    do_op(FUNC_DRAIN);
    // divide with a single nonzero entry
    send_req(FUNC_PUSH, 32'd7);
    do_op(FUNC_DIV);
    do_op(FUNC_DRAIN);
    // wrapping sum, then most negative / -1
    send_req(FUNC_PUSH, 32'h7fff_ffff);
    send_req(FUNC_PUSH, 32'd1);
    do_op(FUNC_ADD);
    send_req(FUNC_PUSH, '1);
    do_op(FUNC_DIV);
    send_req(FUNC_PUSH, '1);
    do_op(FUNC_MUL);
    send_req(FUNC_PUSH, 32'd3);
    do_op(FUNC_SUB);
    // truncation toward zero
    send_req(FUNC_PUSH, word_t'(-7));
    send_req(FUNC_PUSH, 32'd2);
    do_op(FUNC_DIV);
    send_req(FUNC_PUSH, 32'd7);
    send_req(FUNC_PUSH, word_t'(-2));
    do_op(FUNC_DIV);
    do_op(FUNC_NOP6);
    do_op(FUNC_NOP7);
    do_op(FUNC_DRAIN);
    n_directed = n_sent;

    // divides only ever see a nonzero top here; the halt comes at the end
    while (n_sent - n_directed < RAND_REQS) begin
      kind = (n_sent == n_directed) ? 99 : $urandom_range(0, 99);
      if (kind < 40) begin
        reps = $urandom_range(1, 5);
        for (i = 0; i < reps; i++) send_req(FUNC_PUSH, rand_word());
      end else if (kind < 55) begin
        do_op($urandom_range(0, 1) ? FUNC_SUB : FUNC_MUL);
      end else if (kind < 63) begin
        do_op(FUNC_ADD);
      end else if (kind < 73) begin
        do_op(FUNC_ADD);
        send_req(FUNC_PUSH, rand_nonzero());
        do_op(FUNC_DIV);
      end else if (kind < 83) begin
        send_req(FUNC_PUSH, rand_word());
        send_req(FUNC_PUSH, rand_word());
        do_op($urandom_range(0, 1) ? FUNC_SUB : FUNC_MUL);
      end else if (kind < 91) begin
        do_op(FUNC_DRAIN);
      end else if (kind < 95) begin
        do_op($urandom_range(0, 1) ? FUNC_NOP6 : FUNC_NOP7);
      end else if (kind < 98) begin
        do_op(FUNC_DRAIN);
        case ($urandom_range(0, 2))
          0: do_op(FUNC_SUB);
          1: do_op(FUNC_MUL);
          default: begin
            send_req(FUNC_PUSH, rand_nonzero());
            do_op(FUNC_DIV);
          end
        endcase
      end else begin
        // overfill: the last pushes are dropped
        for (i = 0; i < STACK_DEPTH + 2; i++) send_req(FUNC_PUSH, rand_word());
      end
    end

    // divide by zero, then the sticky halt
    do_op(FUNC_DRAIN);
    send_req(FUNC_PUSH, rand_word());
    send_req(FUNC_PUSH, '0);
    do_op(FUNC_DIV);
    send_req(FUNC_PUSH, rand_word());
    do_op(FUNC_DRAIN);
    do_op(FUNC_ADD);
    do_op(FUNC_NOP7);
    in_valid_i <= 1'b0;

    while (owed != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("run covered %0d requests (%0d directed): all operations, unused codes,",
             n_sent, n_directed);
    $display("full stack, underflow, divide by zero and halt; %0d results, %0d flagged",
             checked, flagged);
    if (errors == 0 && owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[rpn_stack_calculator.f]
rtl/rsc_pkg.sv
rtl/rsc_ram.sv
rtl/rsc_div.sv
rtl/rsc_datapath.sv
rtl/rsc_ctrl.sv
rtl/rpn_stack_calculator.sv
sim/rsc_checker.sv
sim/testbench.sv
